@@ design/pll_channel_rate_calculator_core_assert.svh @@
// ----------------------------------------------------------------------------
// pll channel rate calculator assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PLL_CHANNEL_RATE_CALCULATOR_CORE_ASSERT_SVH
`define PLL_CHANNEL_RATE_CALCULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define PRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prc assertion failed");

// condition holds in the following cycle
`define PRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prc assertion failed");

`else

`define PRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define PRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, register indexes, divider tables and word types.
// ----------------------------------------------------------------------------
package prc_pkg;

  // field widths
  localparam int WORD_W    = 32;
  localparam int CH_W      = 3;
  localparam int S1_W      = 17;
  localparam int FAC_W     = 5;
  localparam int AV2_W     = 7;
  localparam int PROD_W    = WORD_W + S1_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int D1_W      = S1_W + FAC_W;
  localparam int DIV_W     = D1_W + AV2_W;
  localparam int CFG_IDX_W = 3;

  // lowest channel enable bit
  localparam int ENABLE_LSB = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDMI_AV1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AV1_AV2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AV2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AV3      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AV3_LAST = 3'd5;

  // divider tables, selector 0..3
  localparam logic [2:0] HDMI_FACTOR [4] = '{3'd1, 3'd2, 3'd4, 3'd6};
  localparam logic [2:0] AV1_FACTOR  [4] = '{3'd1, 3'd2, 3'd5, 3'd5};

  typedef struct packed {
    logic [WORD_W-1:0] vco_freq;
    logic [CH_W-1:0]   channel;
    logic [WORD_W-1:0] sync1_word;
    logic [WORD_W-1:0] sync2_word;
  } prc_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] channel_rate;
    logic             divide_error;
  } prc_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] channel_enable_word;
    logic [WORD_W-1:0] hdmi_av1_word;
    logic [WORD_W-1:0] av1_av2_word;
    logic [WORD_W-1:0] av2_word;
    logic [WORD_W-1:0] av3_word;
    logic [WORD_W-1:0] av3_last_word;
  } prc_cfg_t;

  // word moving down the divider row: dividend/quotient, remainder, divisor
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
  } prc_cell_t;

  // combined hdmi and av1 factor, at most 30
  function automatic logic [FAC_W-1:0] prc_div_factor(input logic [1:0] hsel,
                                                      input logic [1:0] asel);
    logic [2*3-1:0] prod;
    prod = {3'b000, HDMI_FACTOR[hsel]} * {3'b000, AV1_FACTOR[asel]};
    return prod[FAC_W-1:0];
  endfunction

endpackage

@@ design/prc_front.sv @@
// ----------------------------------------------------------------------------
// prc_front
// Two-stage front end: decodes the channel factors, forms the dividend
// (parent * sync2, doubled on av3) and the divisor (sync1 * factors).
// ----------------------------------------------------------------------------
module prc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  prc_pkg::prc_in_t     in_data,
  input  prc_pkg::prc_cfg_t    cfg,
  output logic                 out_valid,
  output prc_pkg::prc_cell_t   out_data
);
  import prc_pkg::*;

  logic [4:0]       en_idx;
  logic             enabled;
  logic [1:0]       hsel;
  logic [1:0]       asel;
  logic [AV2_W-1:0] av2_raw;
  logic             dbl;
  logic [S1_W-1:0]  s1_eff;
  logic [S1_W-1:0]  s2_eff;
  logic [FAC_W-1:0] fac_eff;
  logic [AV2_W-1:0] av2_eff;
  logic             dbl_eff;

  logic              v1_r, v1_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [D1_W-1:0]   d1_r, d1_nxt;
  logic [AV2_W-1:0]  av2_r;
  logic              dbl_r;

  logic              v2_r;
  prc_cell_t         cell_r, cell_nxt;

  // per-channel field selection; channel seven keeps the neutral defaults
  always_comb begin
    hsel    = 2'd0;
    asel    = 2'd0;
    av2_raw = '0;
    dbl     = 1'b0;
    case (in_data.channel)
      3'd0: begin
        hsel    = cfg.hdmi_av1_word[8:7];
        asel    = cfg.hdmi_av1_word[29:28];
        av2_raw = cfg.av1_av2_word[24:18];
        dbl     = cfg.av3_word[7];
      end
      3'd1: begin
        hsel    = cfg.hdmi_av1_word[11:10];
        asel    = cfg.av1_av2_word[1:0];
        av2_raw = cfg.av1_av2_word[31:25];
        dbl     = cfg.av3_word[11];
      end
      3'd2: begin
        hsel    = cfg.hdmi_av1_word[14:13];
        asel    = cfg.av1_av2_word[4:3];
        av2_raw = cfg.av2_word[6:0];
        dbl     = cfg.av3_word[15];
      end
      3'd3: begin
        hsel    = cfg.hdmi_av1_word[17:16];
        asel    = cfg.av1_av2_word[7:6];
        av2_raw = cfg.av2_word[13:7];
        dbl     = cfg.av3_word[19];
      end
      3'd4: begin
        hsel    = cfg.hdmi_av1_word[20:19];
        asel    = cfg.av1_av2_word[10:9];
        av2_raw = cfg.av2_word[20:14];
        dbl     = cfg.av3_word[23];
      end
      3'd5: begin
        hsel    = cfg.hdmi_av1_word[23:22];
        asel    = cfg.av1_av2_word[13:12];
        av2_raw = cfg.av2_word[27:21];
        dbl     = cfg.av3_word[27];
      end
      3'd6: begin
        hsel    = cfg.hdmi_av1_word[26:25];
        asel    = cfg.av1_av2_word[16:15];
        av2_raw = {3'b000, cfg.av2_word[31:28]};
        dbl     = cfg.av3_last_word[0];
      end
      default: begin
        hsel    = 2'd0;
        asel    = 2'd0;
        av2_raw = '0;
        dbl     = 1'b0;
      end
    endcase
  end

  // disabled channel passes the parent rate through a divide by one
  always_comb begin
    en_idx  = 5'(ENABLE_LSB) + {2'b00, in_data.channel};
    enabled = cfg.channel_enable_word[en_idx];
    if (enabled) begin
      s1_eff  = (in_data.channel == 3'd0) ? in_data.sync1_word[20:4]
                                          : in_data.sync1_word[16:0];
      s2_eff  = in_data.sync2_word[16:0];
      fac_eff = prc_div_factor(hsel, asel);
      av2_eff = (av2_raw == '0) ? AV2_W'(1) : av2_raw;
      dbl_eff = dbl;
    end else begin
      s1_eff  = S1_W'(1);
      s2_eff  = S1_W'(1);
      fac_eff = FAC_W'(1);
      av2_eff = AV2_W'(1);
      dbl_eff = 1'b0;
    end
    v1_nxt   = in_valid;
    prod_nxt = {{S1_W{1'b0}}, in_data.vco_freq} * {{WORD_W{1'b0}}, s2_eff};
    d1_nxt   = {{FAC_W{1'b0}}, s1_eff} * {{S1_W{1'b0}}, fac_eff};
  end

  // second stage: doubling and the last divisor factor
  always_comb begin
    cell_nxt.num = dbl_r ? {prod_r, 1'b0} : {1'b0, prod_r};
    cell_nxt.rem = '0;
    cell_nxt.dvs = {{AV2_W{1'b0}}, d1_r} * {{D1_W{1'b0}}, av2_r};
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      d1_r   <= d1_nxt;
      av2_r  <= av2_eff;
      dbl_r  <= dbl_eff;
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = cell_r;

endmodule

@@ design/prc_div_cell.sv @@
// ----------------------------------------------------------------------------
// prc_div_cell
// One restoring division step: shifts in a dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the low end.
// ----------------------------------------------------------------------------
`include "pll_channel_rate_calculator_core_assert.svh"

module prc_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  prc_pkg::prc_cell_t   in_data,
  output logic                 out_valid,
  output prc_pkg::prc_cell_t   out_data
);
  import prc_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;
  logic           valid_r;
  prc_cell_t      cell_r, cell_nxt;

  // trial subtract
  always_comb begin
    trial        = {in_data.rem, in_data.num[NUM_W-1]};
    diff         = trial - {1'b0, in_data.dvs};
    fits         = (trial >= {1'b0, in_data.dvs});
    cell_nxt.num = {in_data.num[NUM_W-2:0], fits};
    cell_nxt.rem = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    cell_nxt.dvs = in_data.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = cell_r;

  // partial remainder always stays below a nonzero divisor
  `PRC_ASSERT_SAME(a_rem_below_dvs, clk, rst_n, valid_r && (cell_r.dvs != '0), cell_r.rem < cell_r.dvs)

endmodule

@@ design/pll_channel_rate_calculator_core.sv @@
// throughput: one word per cycle; two front stages and 50 division cells
// run as one pipeline held only while the output skid register is full
// reset: synchronous active-low rst_n clears all valids and the six
// configuration registers; datapath registers are not reset
// ----------------------------------------------------------------------------
// pll_channel_rate_calculator_core
// Channel output frequency: parent * sync2 (x2 on av3) divided by
// sync1 * hdmi * av1 * av2 through a row of restoring division cells.
// ----------------------------------------------------------------------------
`include "pll_channel_rate_calculator_core_assert.svh"

module pll_channel_rate_calculator_core #(
  parameter int RATE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  prc_pkg::prc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output prc_pkg::prc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prc_pkg::WORD_W-1:0]          cfg_wdata
);
  import prc_pkg::*;

  localparam int KEEP_BITS = (RATE_BITS < NUM_W) ? RATE_BITS : NUM_W;
  localparam logic [NUM_W-1:0] RATE_MASK = {NUM_W{1'b1}} >> (NUM_W - KEEP_BITS);

  prc_cfg_t   cfg_r;
  logic       adv;
  logic       cell_v [NUM_W+1];
  prc_cell_t  cell_d [NUM_W+1];
  prc_out_t   res;
  logic       last_v;
  logic       out_free;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  prc_out_t   out_data_r, out_data_nxt;
  prc_out_t   skid_data_r, skid_data_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHAN_EN:  cfg_r.channel_enable_word <= cfg_wdata;
        CFG_HDMI_AV1: cfg_r.hdmi_av1_word       <= cfg_wdata;
        CFG_AV1_AV2:  cfg_r.av1_av2_word        <= cfg_wdata;
        CFG_AV2:      cfg_r.av2_word            <= cfg_wdata;
        CFG_AV3:      cfg_r.av3_word            <= cfg_wdata;
        CFG_AV3_LAST: cfg_r.av3_last_word       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline moves whenever the skid register is empty
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  prc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_valid (cell_v[0]),
    .out_data  (cell_d[0])
  );

  // division row, one quotient bit per cell
  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    prc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (cell_v[g]),
      .in_data   (cell_d[g]),
      .out_valid (cell_v[g+1]),
      .out_data  (cell_d[g+1])
    );
  end

  // result word from the last cell
  always_comb begin
    last_v           = cell_v[NUM_W];
    res.divide_error = (cell_d[NUM_W].dvs == '0);
    res.channel_rate = res.divide_error ? '0 : (cell_d[NUM_W].num & RATE_MASK);
  end

  // output register with skid stage
  always_comb begin
    out_free       = !out_valid_r || !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (last_v) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid only holds a word behind a held output word
  `PRC_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // a word arriving at a stalled output lands in the skid register
  `PRC_ASSERT_NEXT(a_skid_catches, clk, rst_n, last_v && adv && !out_free, skid_valid_r)
  // zero divisor always reports a zero rate
  `PRC_ASSERT_SAME(a_err_zero_rate, clk, rst_n, out_valid_r && out_data_r.divide_error, out_data_r.channel_rate == '0)

endmodule
